[design/loudness_metadata_packer_top_assert.svh]
// assertion macros used by the checker file of the loudness metadata packer
`ifndef LOUDNESS_METADATA_PACKER_TOP_ASSERT_SVH
`define LOUDNESS_METADATA_PACKER_TOP_ASSERT_SVH

// clocked assertion that is switched off while reset is low
`define LMP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// clocked assertion that also holds across reset
`define LMP_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/lmp_pkg.sv]
// ----------------------------------------------------------------------------
// lmp_pkg
// Types, constants and lookup functions of the loudness metadata packer.
// ----------------------------------------------------------------------------
`default_nettype none

package lmp_pkg;

    // field widths
    localparam int LMP_TYPE_W   = 3;
    localparam int LMP_VALUE_W  = 16;
    localparam int LMP_Q_W      = 10;
    localparam int LMP_BIAS_W   = 11;
    localparam int LMP_MAG_W    = 20;
    localparam int LMP_BIASED_W = 22;
    localparam int LMP_OPCODE_W = 8;
    localparam int LMP_WORD_W   = 32;
    localparam int LMP_STATUS_W = 2;

    // default fraction bits of the input values
    localparam int LMP_VALUE_FRAC_BITS = 8;

    // one lane per value slot
    localparam int LMP_NUM_LANES = 3;

    // packed word layout
    localparam int LMP_FIRST_POS  = 22;
    localparam int LMP_SECOND_POS = 11;
    localparam int LMP_P2_POS     = 21;
    localparam int LMP_P3_POS     = 10;

    // loudness types
    localparam logic [LMP_TYPE_W-1:0] LMP_TYPE_0 = 3'd0;
    localparam logic [LMP_TYPE_W-1:0] LMP_TYPE_1 = 3'd1;
    localparam logic [LMP_TYPE_W-1:0] LMP_TYPE_2 = 3'd2;
    localparam logic [LMP_TYPE_W-1:0] LMP_TYPE_3 = 3'd3;
    localparam logic [LMP_TYPE_W-1:0] LMP_TYPE_4 = 3'd4;
    localparam logic [LMP_TYPE_W-1:0] LMP_TYPE_5 = 3'd5;

    // opcodes
    localparam logic [LMP_OPCODE_W-1:0] LMP_OP_NONE   = 8'h00;
    localparam logic [LMP_OPCODE_W-1:0] LMP_OP_TYPE_0 = 8'h80;
    localparam logic [LMP_OPCODE_W-1:0] LMP_OP_TYPE_1 = 8'h81;
    localparam logic [LMP_OPCODE_W-1:0] LMP_OP_TYPE_2 = 8'h85;
    localparam logic [LMP_OPCODE_W-1:0] LMP_OP_TYPE_3 = 8'h82;
    localparam logic [LMP_OPCODE_W-1:0] LMP_OP_TYPE_4 = 8'h83;
    localparam logic [LMP_OPCODE_W-1:0] LMP_OP_TYPE_5 = 8'h84;

    // status codes
    localparam logic [LMP_STATUS_W-1:0] LMP_STATUS_OK        = 2'd0;
    localparam logic [LMP_STATUS_W-1:0] LMP_STATUS_BAD_TYPE  = 2'd1;
    localparam logic [LMP_STATUS_W-1:0] LMP_STATUS_BAD_VALUE = 2'd2;

    // input item
    typedef struct packed {
        logic [LMP_TYPE_W-1:0]         record_type;
        logic signed [LMP_VALUE_W-1:0] first_value;
        logic                          second_present;
        logic signed [LMP_VALUE_W-1:0] second_value;
        logic                          third_present;
        logic signed [LMP_VALUE_W-1:0] third_value;
    } t_lmp_in;

    // result item
    typedef struct packed {
        logic [LMP_OPCODE_W-1:0] opcode;
        logic [LMP_WORD_W-1:0]   packed_word;
        logic [LMP_STATUS_W-1:0] status;
    } t_lmp_out;

    // what one lane found
    typedef struct packed {
        logic               ok;
        logic [LMP_Q_W-1:0] q;
    } t_lmp_lane_res;

    function automatic logic [LMP_OPCODE_W-1:0] lmp_opcode(input logic [LMP_TYPE_W-1:0] t);
        logic [LMP_OPCODE_W-1:0] op;
        case (t)
            LMP_TYPE_0: op = LMP_OP_TYPE_0;
            LMP_TYPE_1: op = LMP_OP_TYPE_1;
            LMP_TYPE_2: op = LMP_OP_TYPE_2;
            LMP_TYPE_3: op = LMP_OP_TYPE_3;
            LMP_TYPE_4: op = LMP_OP_TYPE_4;
            LMP_TYPE_5: op = LMP_OP_TYPE_5;
            default:    op = LMP_OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic [LMP_BIAS_W-1:0] lmp_bias(input logic [LMP_TYPE_W-1:0] t);
        logic [LMP_BIAS_W-1:0] b;
        case (t)
            LMP_TYPE_0, LMP_TYPE_2: b = 11'd350;
            LMP_TYPE_1:             b = 11'd0;
            LMP_TYPE_3:             b = 11'd10;
            LMP_TYPE_4, LMP_TYPE_5: b = 11'd1000;
            default:                b = 11'd0;
        endcase
        return b;
    endfunction

    function automatic logic [LMP_BIAS_W-1:0] lmp_limit(input logic [LMP_TYPE_W-1:0] t);
        logic [LMP_BIAS_W-1:0] l;
        case (t)
            LMP_TYPE_0, LMP_TYPE_2: l = 11'd330;
            LMP_TYPE_1:             l = 11'd300;
            LMP_TYPE_3:             l = 11'd50;
            LMP_TYPE_4, LMP_TYPE_5: l = 11'd1000;
            default:                l = 11'd0;
        endcase
        return l;
    endfunction

    function automatic logic lmp_type_valid(input logic [LMP_TYPE_W-1:0] t);
        return (t <= LMP_TYPE_5);
    endfunction

endpackage

`default_nettype wire

[design/lmp_lane.sv]
// ----------------------------------------------------------------------------
// lmp_lane
// Quantizes one fixed point value: scale by ten, round half away from zero,
// add the type bias and check it against the type limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lmp_lane #(
    parameter int FracBits = lmp_pkg::LMP_VALUE_FRAC_BITS
) (
    input  wire logic [lmp_pkg::LMP_TYPE_W-1:0]         i_record_type,
    input  wire logic signed [lmp_pkg::LMP_VALUE_W-1:0] i_value,
    output lmp_pkg::t_lmp_lane_res                      o_res
);
    import lmp_pkg::*;

    localparam logic [LMP_MAG_W-1:0] RoundHalf = LMP_MAG_W'(1) << (FracBits - 1);

    logic                           w_neg;
    logic signed [LMP_VALUE_W:0]    w_ext;
    logic [LMP_VALUE_W:0]           w_abs;
    logic [LMP_MAG_W-1:0]           w_abs_x;
    logic [LMP_MAG_W-1:0]           w_mag10;
    logic [LMP_MAG_W-1:0]           w_r;
    logic signed [LMP_BIASED_W-1:0] w_r_s;
    logic signed [LMP_BIASED_W-1:0] w_rounded;
    logic signed [LMP_BIASED_W-1:0] w_biased;
    logic signed [LMP_BIASED_W-1:0] w_limit;

    // magnitude times ten as two shifted adds
    always_comb begin
        w_neg   = i_value[LMP_VALUE_W-1];
        w_ext   = {i_value[LMP_VALUE_W-1], i_value};
        w_abs   = w_neg ? -w_ext : w_ext;
        w_abs_x = LMP_MAG_W'(w_abs);
        w_mag10 = (w_abs_x << 3) + (w_abs_x << 1);
    end

    // round half away from zero, then restore the sign and add the bias
    always_comb begin
        w_r       = (w_mag10 + RoundHalf) >> FracBits;
        w_r_s     = $signed(LMP_BIASED_W'(w_r));
        w_rounded = w_neg ? -w_r_s : w_r_s;
        w_biased  = w_rounded + $signed(LMP_BIASED_W'(lmp_bias(i_record_type)));
        w_limit   = $signed(LMP_BIASED_W'(lmp_limit(i_record_type)));
    end

    // range check against zero and the type limit
    always_comb begin
        o_res.ok = !w_biased[LMP_BIASED_W-1] && (w_biased <= w_limit);
        o_res.q  = w_biased[LMP_Q_W-1:0];
    end

endmodule

`default_nettype wire

[design/lmp_merge.sv]
// ----------------------------------------------------------------------------
// lmp_merge
// Combines the lane results into one status, opcode and packed word.
// ----------------------------------------------------------------------------
`default_nettype none

module lmp_merge (
    input  wire logic [lmp_pkg::LMP_TYPE_W-1:0]                          i_record_type,
    input  wire logic                                                     i_second_present,
    input  wire logic                                                     i_third_present,
    input  wire lmp_pkg::t_lmp_lane_res [lmp_pkg::LMP_NUM_LANES-1:0]      i_lane,
    output lmp_pkg::t_lmp_out                                             o_out
);
    import lmp_pkg::*;

    logic               w_all_ok;
    logic [LMP_Q_W-1:0] w_q1;
    logic [LMP_Q_W-1:0] w_q2;

    // absent values never fail and pack as zero
    always_comb begin
        w_all_ok = i_lane[0].ok
                 && (!i_second_present || i_lane[1].ok)
                 && (!i_third_present  || i_lane[2].ok);
        w_q1 = i_second_present ? i_lane[1].q : '0;
        w_q2 = i_third_present  ? i_lane[2].q : '0;
    end

    // bad type wins over a bad value
    always_comb begin
        o_out = '0;
        if (!lmp_type_valid(i_record_type)) begin
            o_out.status = LMP_STATUS_BAD_TYPE;
        end else if (!w_all_ok) begin
            o_out.status = LMP_STATUS_BAD_VALUE;
        end else begin
            o_out.status      = LMP_STATUS_OK;
            o_out.opcode      = lmp_opcode(i_record_type);
            o_out.packed_word = (LMP_WORD_W'(i_lane[0].q) << LMP_FIRST_POS)
                              | (LMP_WORD_W'(i_second_present) << LMP_P2_POS)
                              | (LMP_WORD_W'(w_q1) << LMP_SECOND_POS)
                              | (LMP_WORD_W'(i_third_present) << LMP_P3_POS)
                              | LMP_WORD_W'(w_q2);
        end
    end

endmodule

`default_nettype wire

[design/loudness_metadata_packer_top.sv]
// ----------------------------------------------------------------------------
// loudness_metadata_packer_top
// Packs one loudness record into an opcode, a 32-bit metadata word and a status.
// ----------------------------------------------------------------------------
// The block takes one record per clock and returns one result item for each
// record, in order. An accepted record is held in the lane stage register and
// then in the output register, from which it is offered as a result item: the
// first stage is three quantizer lanes, one per value slot, feeding a register;
// the second stage merges the lane results into the packed word and holds it
// in the output register. Both stages advance independently, so a new record
// is still taken while a finished result waits at the output as long as the
// lane stage is empty; with both stages full and the output stalled, input
// ready drops until the output side takes the waiting item. Throughput is one
// item per cycle while the output side is ready.
`default_nettype none

module loudness_metadata_packer_top #(
    parameter int VALUE_FRAC_BITS = lmp_pkg::LMP_VALUE_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire lmp_pkg::t_lmp_in  i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output lmp_pkg::t_lmp_out o_out_data
);
    import lmp_pkg::*;

    logic signed [LMP_VALUE_W-1:0]       w_value [LMP_NUM_LANES];
    t_lmp_lane_res [LMP_NUM_LANES-1:0]   w_lane;
    t_lmp_out                            w_merged;
    logic                                w_out_take;
    logic                                w_s1_take;

    logic                                r_s1_valid;
    logic                                n_s1_valid;
    logic [LMP_TYPE_W-1:0]               r_s1_type;
    logic                                r_s1_p2;
    logic                                r_s1_p3;
    t_lmp_lane_res [LMP_NUM_LANES-1:0]   r_s1_lane;
    logic                                r_out_valid;
    logic                                n_out_valid;
    t_lmp_out                            r_out_data;

    // value slots feeding the lanes
    always_comb begin
        w_value[0] = i_in_data.first_value;
        w_value[1] = i_in_data.second_value;
        w_value[2] = i_in_data.third_value;
    end

    // quantizer lanes
    for (genvar g = 0; g < LMP_NUM_LANES; g++) begin : g_lane
        lmp_lane #(
            .FracBits (VALUE_FRAC_BITS)
        ) u_lmp_lane (
            .i_record_type (i_in_data.record_type),
            .i_value       (w_value[g]),
            .o_res         (w_lane[g])
        );
    end

    // merge of the registered lane results
    lmp_merge u_lmp_merge (
        .i_record_type    (r_s1_type),
        .i_second_present (r_s1_p2),
        .i_third_present  (r_s1_p3),
        .i_lane           (r_s1_lane),
        .o_out            (w_merged)
    );

    // pipeline flow control
    always_comb begin
        w_out_take  = !r_out_valid || i_out_ready;
        w_s1_take   = !r_s1_valid || w_out_take;
        n_s1_valid  = w_s1_take ? i_in_valid : r_s1_valid;
        n_out_valid = w_out_take ? r_s1_valid : r_out_valid;
        o_in_ready  = w_s1_take;
        o_out_valid = r_out_valid;
        o_out_data  = r_out_data;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // lane stage payload
    always_ff @(posedge i_clk) begin
        if (w_s1_take && i_in_valid) begin
            r_s1_type <= i_in_data.record_type;
            r_s1_p2   <= i_in_data.second_present;
            r_s1_p3   <= i_in_data.third_present;
            r_s1_lane <= w_lane;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_out_take && r_s1_valid) begin
            r_out_data <= w_merged;
        end
    end

endmodule

`default_nettype wire

[design/lmp_checker.sv]
// ----------------------------------------------------------------------------
// lmp_checker
// Port level checks of the loudness metadata packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "loudness_metadata_packer_top_assert.svh"

module lmp_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire lmp_pkg::t_lmp_out i_out_data
);
    import lmp_pkg::*;

    // nothing comes out right after reset
    `LMP_ASSERT(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // a stalled result holds
    `LMP_ASSERT_RST(a_stall_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data),
        "stalled result changed")

    // an error result carries no opcode and no word
    `LMP_ASSERT_RST(a_error_zero, i_clk, i_rst_n,
        i_out_valid && (i_out_data.status != LMP_STATUS_OK)
            |-> (i_out_data.opcode == LMP_OP_NONE) && (i_out_data.packed_word == '0),
        "error result not cleared")

    // a good result has an opcode from the table and a known status
    `LMP_ASSERT_RST(a_ok_opcode, i_clk, i_rst_n,
        i_out_valid && (i_out_data.status == LMP_STATUS_OK)
            |-> (i_out_data.opcode >= LMP_OP_TYPE_0) && (i_out_data.opcode <= LMP_OP_TYPE_2),
        "good result with bad opcode")

    // status never takes the unused code
    `LMP_ASSERT_RST(a_status_code, i_clk, i_rst_n,
        i_out_valid |-> (i_out_data.status == LMP_STATUS_OK)
            || (i_out_data.status == LMP_STATUS_BAD_TYPE)
            || (i_out_data.status == LMP_STATUS_BAD_VALUE),
        "unused status code")

endmodule

bind loudness_metadata_packer_top lmp_checker u_lmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire
